FILE: rtl/mts_pkg.sv
package mts_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int DATA_W          = 32;
  localparam int OCC_W           = 11;
  localparam int FAULT_W         = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_OK        = 2'd0,
    FAULT_POP_EMPTY = 2'd1,
    FAULT_PUSH_FULL = 2'd2
  } fault_t;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic exec;
    logic finish;
  } cmd_t;

endpackage

FILE: rtl/mts_ctrl.sv
module mts_ctrl import mts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/mts_datapath.sv
module mts_datapath import mts_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic                     in_op,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic signed [DATA_W-1:0] out_top_value,
  output logic signed [DATA_W-1:0] out_min_value,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_is_empty,
  output logic [FAULT_W-1:0]       out_fault
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic signed [DATA_W-1:0] vmem [STACK_DEPTH];
  logic signed [DATA_W-1:0] mmem [STACK_DEPTH];

  logic [CW-1:0]            vc_r;
  logic [CW-1:0]            mc_r;
  logic signed [DATA_W-1:0] top_r;
  logic signed [DATA_W-1:0] min_r;
  logic                     pend_pop_r;
  logic                     drop_r;
  fault_t                   fault_r;
  logic signed [DATA_W-1:0] vrd_r;
  logic signed [DATA_W-1:0] mrd_r;

  logic signed [DATA_W-1:0] top_fin;
  logic signed [DATA_W-1:0] min_fin;
  logic                     is_full;
  logic                     is_empty;
  logic                     do_push;
  logic                     do_pop;
  logic                     min_push;
  logic                     min_drop;

  assign is_full  = (vc_r == CW'(STACK_DEPTH));
  assign is_empty = (vc_r == '0);
  assign do_push  = cmd.exec && (in_op == OP_PUSH) && !is_full;
  assign do_pop   = cmd.exec && (in_op == OP_POP) && !is_empty;
  assign min_push = do_push && ((mc_r == '0) || (min_r >= in_push_value))
                    && (mc_r < CW'(STACK_DEPTH));
  assign min_drop = do_pop && (mc_r != '0) && (top_r == min_r);

  always_ff @(posedge clk) begin
    if (do_push) begin
      vmem[AW'(vc_r)] <= in_push_value;
    end
    if (do_pop) begin
      vrd_r <= vmem[AW'(vc_r - CW'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (min_push) begin
      mmem[AW'(mc_r)] <= in_push_value;
    end
    if (min_drop) begin
      mrd_r <= mmem[AW'(mc_r - CW'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r       <= '0;
      mc_r       <= '0;
      pend_pop_r <= 1'b0;
      drop_r     <= 1'b0;
      fault_r    <= FAULT_OK;
    end else if (cmd.exec) begin
      pend_pop_r <= do_pop;
      drop_r     <= min_drop;
      if (do_push) begin
        vc_r <= vc_r + CW'(1);
      end else if (do_pop) begin
        vc_r <= vc_r - CW'(1);
      end
      if (min_push) begin
        mc_r <= mc_r + CW'(1);
      end else if (min_drop) begin
        mc_r <= mc_r - CW'(1);
      end
      if (in_op == OP_PUSH) begin
        fault_r <= is_full ? FAULT_PUSH_FULL : FAULT_OK;
      end else begin
        fault_r <= is_empty ? FAULT_POP_EMPTY : FAULT_OK;
      end
    end
  end

  assign top_fin = pend_pop_r ? vrd_r : top_r;
  assign min_fin = drop_r ? mrd_r : min_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      top_r <= in_push_value;
    end else if (cmd.finish) begin
      top_r <= top_fin;
    end
    if (min_push) begin
      min_r <= in_push_value;
    end else if (cmd.finish) begin
      min_r <= min_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_top_value <= (vc_r == '0) ? '0 : top_fin;
      out_min_value <= ((vc_r == '0) || (mc_r == '0)) ? '0 : min_fin;
      out_occupancy <= OCC_W'(vc_r);
      out_is_empty  <= (vc_r == '0);
      out_fault     <= fault_r;
    end
  end

endmodule

FILE: rtl/min_tracking_stack.sv
// Stack of signed 32-bit values that also reports the running minimum. Each
// beat on the input is a push or a pop and yields exactly one result beat with
// the top value, the minimum, the occupancy, an empty flag and a fault code
// (pop on an empty stack and push onto a full stack leave the stack unchanged).
// Each operation first updates the counts and issues the synchronous reads of
// the value and minimum memories, then, once the result side is free, picks up
// the new top and minimum after a pop and loads the output register. No new beat
// is taken until the last one has loaded its result. The memories are not
// cleared at reset; only the counts, the pending-pop flags and the fault code are.
module min_tracking_stack import mts_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_top_value,
  output logic signed [DATA_W-1:0] out_min_value,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_is_empty,
  output logic [FAULT_W-1:0]       out_fault
);

  cmd_t cmd;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_op         (in_op),
    .in_push_value (in_push_value),
    .out_top_value (out_top_value),
    .out_min_value (out_min_value),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_fault     (out_fault)
  );

endmodule
